FILE: rtl/core/ytr_pkg.sv
// ----------------------------------------------------------------------------
// ytr_pkg: shared types, codes and arithmetic helpers
// Pixel and result structs, register codes, divisor and reciprocal tables
// for sample normalization, matrix coefficients and small divide helpers.
// ----------------------------------------------------------------------------
package ytr_pkg;

  // Pipeline depth of each part, in register stages
  localparam int LAT_IN     = 1;
  localparam int LAT_NORM   = 4;
  localparam int LAT_MAT    = 2;
  localparam int DIV_STAGES = 8;
  localparam int LAT_ALPHA  = DIV_STAGES + 2;
  localparam int LAT_OUT    = 2;
  localparam int LAT_TOTAL  = LAT_IN + LAT_NORM + LAT_MAT + LAT_ALPHA + LAT_OUT;

  // Sample depth codes; the spare code counts as 12 bits
  localparam logic [1:0] DEPTH_8    = 2'd0;
  localparam logic [1:0] DEPTH_10   = 2'd1;
  localparam logic [1:0] DEPTH_12   = 2'd2;
  localparam logic [1:0] DEPTH_RSVD = 2'd3;

  // Alpha depth codes
  localparam logic [1:0] ADEPTH_NONE = 2'd0;
  localparam logic [1:0] ADEPTH_8    = 2'd1;
  localparam logic [1:0] ADEPTH_10   = 2'd2;
  localparam logic [1:0] ADEPTH_12   = 2'd3;

  // Matrix codes
  localparam logic [1:0] MODE_IDENTITY = 2'd0;
  localparam logic [1:0] MODE_BT709    = 2'd1;
  localparam logic [1:0] MODE_BT601    = 2'd2;
  localparam logic [1:0] MODE_BT2020   = 2'd3;

  // Alpha actions; the spare code leaves color alone
  localparam logic [1:0] ACT_LEAVE     = 2'd0;
  localparam logic [1:0] ACT_PREMUL    = 2'd1;
  localparam logic [1:0] ACT_UNPREMUL  = 2'd2;
  localparam logic [1:0] ACT_RSVD      = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_DEPTH       = 3'd0;
  localparam logic [2:0] REG_FULL_RANGE  = 3'd1;
  localparam logic [2:0] REG_MATRIX      = 3'd2;
  localparam logic [2:0] REG_MONO        = 3'd3;
  localparam logic [2:0] REG_ALPHA_DEPTH = 3'd4;
  localparam logic [2:0] REG_ALPHA_FULL  = 3'd5;
  localparam logic [2:0] REG_ALPHA_ACT   = 3'd6;
  localparam logic [2:0] REG_OUT8        = 3'd7;

  typedef struct packed {
    logic [11:0] luma_sample;
    logic [11:0] cb_sample;
    logic [11:0] cr_sample;
    logic [11:0] alpha_level;
  } pix_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha_out;
    logic        data_error;
  } res_t;

  typedef struct packed {
    logic [16:0] kr;
    logic [16:0] kgb;
    logic [16:0] kgr;
    logic [16:0] kb;
  } coef_t;

  // Normalization divisor for a depth and range
  function automatic logic [11:0] norm_den(input logic [1:0] bits_code, input logic full,
                                           input logic chroma);
    logic [11:0] d;
    priority if (full) begin
      case (bits_code)
        DEPTH_8:  d = 12'd255;
        DEPTH_10: d = 12'd1023;
        default:  d = 12'd4095;
      endcase
    end else if (chroma) begin
      case (bits_code)
        DEPTH_8:  d = 12'd224;
        DEPTH_10: d = 12'd896;
        default:  d = 12'd3584;
      endcase
    end else begin
      case (bits_code)
        DEPTH_8:  d = 12'd219;
        DEPTH_10: d = 12'd876;
        default:  d = 12'd3504;
      endcase
    end
    return d;
  endfunction

  // floor(2^32 / norm_den), same selection
  function automatic logic [24:0] norm_recip(input logic [1:0] bits_code, input logic full,
                                             input logic chroma);
    logic [24:0] m;
    priority if (full) begin
      case (bits_code)
        DEPTH_8:  m = 25'd16843009;
        DEPTH_10: m = 25'd4198404;
        default:  m = 25'd1048832;
      endcase
    end else if (chroma) begin
      case (bits_code)
        DEPTH_8:  m = 25'd19173961;
        DEPTH_10: m = 25'd4793490;
        default:  m = 25'd1198372;
      endcase
    end else begin
      case (bits_code)
        DEPTH_8:  m = 25'd19611722;
        DEPTH_10: m = 25'd4902930;
        default:  m = 25'd1225732;
      endcase
    end
    return m;
  endfunction

  function automatic coef_t mat_coef(input logic [1:0] mode);
    coef_t k;
    unique case (mode)
      MODE_IDENTITY, MODE_BT709: k = '{17'd103206, 17'd12276, 17'd30679, 17'd121609};
      MODE_BT601:                k = '{17'd91881,  17'd22553, 17'd46802, 17'd116130};
      MODE_BT2020:               k = '{17'd96639,  17'd10784, 17'd37444, 17'd123299};
    endcase
    return k;
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [21:0] v);
    logic [15:0] c;
    priority if (v <= 22'sd0) begin
      c = 16'd0;
    end else if (v >= 22'sd65535) begin
      c = 16'hFFFF;
    end else begin
      c = v[15:0];
    end
    return c;
  endfunction

  // floor(x / 65535) for results that fit 16 bits
  function automatic logic [15:0] div65535(input logic [31:0] x);
    logic [32:0] s;
    logic [16:0] q0;
    logic [33:0] r;
    s  = {1'b0, x} + {17'd0, x[31:16]};
    q0 = s[32:16];
    r  = {2'b0, x} + {17'd0, q0} - {1'b0, q0, 16'd0};
    if (r >= 34'd65535) begin
      q0 = q0 + 17'd1;
    end
    return q0[15:0];
  endfunction

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nbit,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] res;
    t = {rem, nbit};
    if (t >= {1'b0, d}) begin
      res = {1'b1, 16'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[15:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/yuv_to_rgb_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_converter_top: YCbCr to RGB pixel converter
// Normalizes, converts, applies alpha and optionally reduces one pixel
// per clock in a fixed-latency pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive pixel and raise start; a transfer happens at every rising
//   edge with start high and busy low. busy stays low, so a new pixel may
//   be sent in every cycle.
//   Output: done is high for exactly one cycle while result holds the
//   pixel's color, alpha and error flag; that cycle is the transfer.
//   The receiver cannot hold results off and needs no flow control.
//   Path: a transferred pixel passes the input register, the normalizers,
//   the matrix, the alpha stage and the output stages before it shows on
//   result. Throughput: one pixel per cycle, set by the fully pipelined
//   datapath (four-stage normalizers, two-stage matrix, eight-stage
//   unpremultiply dividers, two-stage 8-bit reduction).
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at the
//   clock edge; write only while no pixel is in flight.
//   Reset: rst (synchronous) drops every pixel in flight and restores the
//   register defaults; no result strobe follows until new input.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_converter_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ytr_pkg::pix_t pixel,
  output logic          done,
  output ytr_pkg::res_t result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [1:0]    cfg_wdata
);

  localparam int LAT = ytr_pkg::LAT_TOTAL;

  // Configuration registers
  logic [1:0] depth_code;
  logic       full_swing;
  logic [1:0] matrix_mode;
  logic       monochrome;
  logic [1:0] alpha_depth_code;
  logic       alpha_full_range;
  logic [1:0] alpha_action;
  logic       output_8bit;

  logic [1:0]  bits_code;
  logic [1:0]  abits_code;
  logic        alpha_plane;
  logic        chroma_mode;
  logic [11:0] maxv;
  logic [11:0] amax;
  logic        err_in;
  logic        take;

  ytr_pkg::pix_t pix_q;
  logic          vld_pipe [LAT];
  logic          err_pipe [LAT-1];

  logic signed [21:0] y_n;
  logic signed [21:0] cb_n;
  logic signed [21:0] cr_n;
  logic signed [21:0] a_n;

  logic [15:0]      a_d1;
  logic [15:0]      a_d2;
  logic [2:0][15:0] rgb_m;
  logic [2:0][15:0] rgb_a;
  logic [15:0]      a_a;

  logic [3:0][15:0] f_in;
  logic [3:0][15:0] f_v;
  logic [3:0][23:0] f_p;
  logic [3:0][15:0] f_o;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code       <= ytr_pkg::DEPTH_8;
      full_swing       <= 1'b1;
      matrix_mode      <= ytr_pkg::MODE_BT709;
      monochrome       <= 1'b0;
      alpha_depth_code <= ytr_pkg::ADEPTH_NONE;
      alpha_full_range <= 1'b1;
      alpha_action     <= ytr_pkg::ACT_LEAVE;
      output_8bit      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ytr_pkg::REG_DEPTH:       depth_code       <= cfg_wdata;
        ytr_pkg::REG_FULL_RANGE:  full_swing       <= cfg_wdata[0];
        ytr_pkg::REG_MATRIX:      matrix_mode      <= cfg_wdata;
        ytr_pkg::REG_MONO:        monochrome       <= cfg_wdata[0];
        ytr_pkg::REG_ALPHA_DEPTH: alpha_depth_code <= cfg_wdata;
        ytr_pkg::REG_ALPHA_FULL:  alpha_full_range <= cfg_wdata[0];
        ytr_pkg::REG_ALPHA_ACT:   alpha_action     <= cfg_wdata;
        ytr_pkg::REG_OUT8:        output_8bit      <= cfg_wdata[0];
      endcase
    end
  end

  // Depth decode and range check; depth code three counts as 12 bits
  always_comb begin
    bits_code   = (depth_code == ytr_pkg::DEPTH_8 || depth_code == ytr_pkg::DEPTH_10) ?
                  depth_code : ytr_pkg::DEPTH_12;
    abits_code  = alpha_depth_code - 2'd1;
    alpha_plane = alpha_depth_code != ytr_pkg::ADEPTH_NONE;
    chroma_mode = !monochrome && matrix_mode != ytr_pkg::MODE_IDENTITY;
    unique case (bits_code)
      ytr_pkg::DEPTH_8:  maxv = 12'd255;
      ytr_pkg::DEPTH_10: maxv = 12'd1023;
      default:           maxv = 12'd4095;
    endcase
    unique case (abits_code)
      ytr_pkg::DEPTH_8:  amax = 12'd255;
      ytr_pkg::DEPTH_10: amax = 12'd1023;
      default:           amax = 12'd4095;
    endcase
    err_in = (pixel.luma_sample > maxv) ||
             (!monochrome && (pixel.cb_sample > maxv || pixel.cr_sample > maxv)) ||
             (alpha_plane && pixel.alpha_level > amax);
  end

  // Input register and valid / error lines that follow every pixel
  always_ff @(posedge clk) begin
    pix_q <= pixel;
    err_pipe[0] <= err_in;
    for (int k = 1; k < LAT - 1; k++) begin
      err_pipe[k] <= err_pipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld_pipe[k] <= 1'b0;
      end
    end else begin
      vld_pipe[0] <= take;
      for (int k = 1; k < LAT; k++) begin
        vld_pipe[k] <= vld_pipe[k-1];
      end
    end
  end

  ytr_norm u_norm_y (
    .clk       (clk),
    .sample    (pix_q.luma_sample),
    .bits_code (bits_code),
    .full      (full_swing),
    .chroma    (1'b0),
    .value     (y_n)
  );

  ytr_norm u_norm_cb (
    .clk       (clk),
    .sample    (pix_q.cb_sample),
    .bits_code (bits_code),
    .full      (full_swing),
    .chroma    (chroma_mode),
    .value     (cb_n)
  );

  ytr_norm u_norm_cr (
    .clk       (clk),
    .sample    (pix_q.cr_sample),
    .bits_code (bits_code),
    .full      (full_swing),
    .chroma    (chroma_mode),
    .value     (cr_n)
  );

  ytr_norm u_norm_a (
    .clk       (clk),
    .sample    (pix_q.alpha_level),
    .bits_code (abits_code),
    .full      (alpha_full_range),
    .chroma    (1'b0),
    .value     (a_n)
  );

  ytr_matrix u_matrix (
    .clk         (clk),
    .y           (y_n),
    .cb          (cb_n),
    .cr          (cr_n),
    .matrix_mode (matrix_mode),
    .monochrome  (monochrome),
    .red         (rgb_m[2]),
    .green       (rgb_m[1]),
    .blue        (rgb_m[0])
  );

  // Hold alpha beside the matrix; full opacity without an alpha plane
  always_ff @(posedge clk) begin
    a_d1 <= alpha_plane ? ytr_pkg::clamp16(a_n) : 16'hFFFF;
    a_d2 <= a_d1;
  end

  ytr_alpha u_alpha (
    .clk         (clk),
    .color_in    (rgb_m),
    .alpha_in    (a_d2),
    .alpha_plane (alpha_plane),
    .action      (alpha_action),
    .color_out   (rgb_a),
    .alpha_out   (a_a)
  );

  // Output stage 1: scale by 255 with half-step rounding term
  assign f_in = {rgb_a[2], rgb_a[1], rgb_a[0], a_a};

  always_ff @(posedge clk) begin
    f_v <= f_in;
    for (int ch = 0; ch < 4; ch++) begin
      f_p[ch] <= {f_in[ch], 8'd0} - {8'd0, f_in[ch]} + 24'd32767;
    end
  end

  // Output stage 2: optional 8-bit divide; zero color and alpha on an error
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      f_o[ch] = output_8bit ? ytr_pkg::div65535({8'd0, f_p[ch]}) : f_v[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (err_pipe[LAT-2]) begin
      result <= '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
    end else begin
      result <= '{f_o[3], f_o[2], f_o[1], f_o[0], 1'b0};
    end
  end

  assign done = vld_pipe[LAT-1];

endmodule

FILE: rtl/core/ytr_norm.sv
// ----------------------------------------------------------------------------
// ytr_norm: sample normalizer
// Scales one sample to 16-bit units for full or limited range, luma or
// chroma offset, rounding half away from zero. Four register stages.
// ----------------------------------------------------------------------------
module ytr_norm (
  input  logic               clk,
  input  logic [11:0]        sample,
  input  logic [1:0]         bits_code,
  input  logic               full,
  input  logic               chroma,
  output logic signed [21:0] value
);

  logic [2:0]         sh;
  logic [12:0]        off;
  logic signed [13:0] diff;
  logic               neg;
  logic [12:0]        mag;
  logic [11:0]        den;
  logic [28:0]        x;

  logic [28:0] s1_x;
  logic        s1_neg;
  logic [11:0] s1_den;
  logic [24:0] s1_m;

  logic [53:0] prod;
  logic [20:0] s2_q0;
  logic [28:0] s2_x;
  logic        s2_neg;
  logic [11:0] s2_den;

  logic [32:0] s3_qd;
  logic [20:0] s3_q0;
  logic [28:0] s3_x;
  logic        s3_neg;
  logic [11:0] s3_den;

  logic [32:0] rem;
  logic [20:0] q;

  always_comb begin
    unique case (bits_code)
      ytr_pkg::DEPTH_8:  sh = 3'd0;
      ytr_pkg::DEPTH_10: sh = 3'd2;
      default:           sh = 3'd4;
    endcase
    priority if (chroma) begin
      off = 13'd128 << sh;
    end else if (full) begin
      off = 13'd0;
    end else begin
      off = 13'd16 << sh;
    end
    diff = $signed({2'b00, sample}) - $signed({1'b0, off});
    neg  = diff[13];
    mag  = neg ? 13'(-diff) : diff[12:0];
    den  = ytr_pkg::norm_den(bits_code, full, chroma);
    x    = {mag, 16'd0} - {16'd0, mag} + {18'd0, den[11:1]};
  end

  // Stage 1: magnitude times 65535 plus half divisor
  always_ff @(posedge clk) begin
    s1_x   <= x;
    s1_neg <= neg;
    s1_den <= den;
    s1_m   <= ytr_pkg::norm_recip(bits_code, full, chroma);
  end

  // Stage 2: reciprocal estimate, low by at most one
  assign prod = s1_x * s1_m;

  always_ff @(posedge clk) begin
    s2_q0  <= prod[52:32];
    s2_x   <= s1_x;
    s2_neg <= s1_neg;
    s2_den <= s1_den;
  end

  // Stage 3: back-multiply the estimate
  always_ff @(posedge clk) begin
    s3_qd  <= s2_q0 * s2_den;
    s3_q0  <= s2_q0;
    s3_x   <= s2_x;
    s3_neg <= s2_neg;
    s3_den <= s2_den;
  end

  // Stage 4: correct and restore sign
  always_comb begin
    rem = {4'd0, s3_x} - s3_qd;
    q   = s3_q0 + {20'd0, (rem >= {21'd0, s3_den})};
  end

  always_ff @(posedge clk) begin
    value <= s3_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

endmodule

FILE: rtl/core/ytr_matrix.sv
// ----------------------------------------------------------------------------
// ytr_matrix: color matrix
// Forms red, green and blue from normalized luma and chroma through the
// selected coefficients, identity or luma copy. Two register stages.
// ----------------------------------------------------------------------------
module ytr_matrix (
  input  logic               clk,
  input  logic signed [21:0] y,
  input  logic signed [21:0] cb,
  input  logic signed [21:0] cr,
  input  logic [1:0]         matrix_mode,
  input  logic               monochrome,
  output logic [15:0]        red,
  output logic [15:0]        green,
  output logic [15:0]        blue
);

  ytr_pkg::coef_t     k;
  logic signed [17:0] cbs;
  logic signed [17:0] crs;

  logic signed [35:0] p_r;
  logic signed [35:0] p_gb;
  logic signed [35:0] p_gr;
  logic signed [35:0] p_b;
  logic [15:0]        yc;
  logic [15:0]        id_r;
  logic [15:0]        id_b;

  logic signed [37:0] yf;
  logic [15:0]        m_r;
  logic [15:0]        m_g;
  logic [15:0]        m_b;

  function automatic logic [15:0] rnd_clamp(input logic signed [37:0] s);
    logic signed [37:0] t;
    logic [15:0]        c;
    t = (s + 38'sd32768) >>> 16;
    priority if (s <= 38'sd0) begin
      c = 16'd0;
    end else if (t > 38'sd65535) begin
      c = 16'hFFFF;
    end else begin
      c = t[15:0];
    end
    return c;
  endfunction

  always_comb begin
    k   = ytr_pkg::mat_coef(matrix_mode);
    cbs = cb[17:0];
    crs = cr[17:0];
  end

  // Stage 1: coefficient products
  always_ff @(posedge clk) begin
    p_r  <= $signed({1'b0, k.kr})  * crs;
    p_gb <= $signed({1'b0, k.kgb}) * cbs;
    p_gr <= $signed({1'b0, k.kgr}) * crs;
    p_b  <= $signed({1'b0, k.kb})  * cbs;
    yc   <= ytr_pkg::clamp16(y);
    id_r <= ytr_pkg::clamp16(cr);
    id_b <= ytr_pkg::clamp16(cb);
  end

  // Stage 2: sum, round, clamp and pick the mode
  always_comb begin
    yf  = $signed({6'd0, yc, 16'd0});
    m_r = rnd_clamp(yf + 38'(p_r));
    m_g = rnd_clamp(yf - 38'(p_gb) - 38'(p_gr));
    m_b = rnd_clamp(yf + 38'(p_b));
  end

  always_ff @(posedge clk) begin
    priority if (monochrome) begin
      red   <= yc;
      green <= yc;
      blue  <= yc;
    end else if (matrix_mode == ytr_pkg::MODE_IDENTITY) begin
      red   <= id_r;
      green <= yc;
      blue  <= id_b;
    end else begin
      red   <= m_r;
      green <= m_g;
      blue  <= m_b;
    end
  end

endmodule

FILE: rtl/core/ytr_udiv.sv
// ----------------------------------------------------------------------------
// ytr_udiv: pipelined restoring divider
// 32-bit numerator by 16-bit divisor, 16-bit quotient; the numerator's
// upper half must be below the divisor. Two quotient bits per stage.
// ----------------------------------------------------------------------------
module ytr_udiv (
  input  logic        clk,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic [15:0] quo
);

  localparam int N = ytr_pkg::DIV_STAGES;

  logic [15:0] rem_q [N];
  logic [15:0] low_q [N];
  logic [15:0] quo_q [N];
  logic [15:0] den_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [15:0] rem_i;
    logic [15:0] low_i;
    logic [15:0] quo_i;
    logic [15:0] den_i;
    logic [16:0] st1;
    logic [16:0] st2;

    if (k == 0) begin : g_head
      assign rem_i = num[31:16];
      assign low_i = num[15:0];
      assign quo_i = 16'd0;
      assign den_i = den;
    end else begin : g_body
      assign rem_i = rem_q[k-1];
      assign low_i = low_q[k-1];
      assign quo_i = quo_q[k-1];
      assign den_i = den_q[k-1];
    end

    always_comb begin
      st1 = ytr_pkg::div_step(rem_i, low_i[15], den_i);
      st2 = ytr_pkg::div_step(st1[15:0], low_i[14], den_i);
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= st2[15:0];
      low_q[k] <= {low_i[13:0], 2'b00};
      quo_q[k] <= {quo_i[13:0], st1[16], st2[16]};
      den_q[k] <= den_i;
    end
  end

  assign quo = quo_q[N-1];

endmodule

FILE: rtl/core/ytr_alpha.sv
// ----------------------------------------------------------------------------
// ytr_alpha: alpha premultiply / unpremultiply
// Applies the alpha action to three color channels. Unpremultiply runs
// through one pipelined divider per channel; other paths are delayed to match.
// ----------------------------------------------------------------------------
module ytr_alpha (
  input  logic             clk,
  input  logic [2:0][15:0] color_in,
  input  logic [15:0]      alpha_in,
  input  logic             alpha_plane,
  input  logic [1:0]       action,
  output logic [2:0][15:0] color_out,
  output logic [15:0]      alpha_out
);

  localparam int N = ytr_pkg::DIV_STAGES;

  logic [2:0][31:0] p1_pm;
  logic [2:0][31:0] p1_num;
  logic [2:0]       p1_sat;
  logic [2:0][15:0] p1_c;
  logic [15:0]      p1_a;

  logic [2:0][31:0] pm_d  [N];
  logic [2:0]       sat_d [N];
  logic [2:0][15:0] c_d   [N];
  logic [15:0]      a_d   [N];

  logic [2:0][15:0] quo;

  // Stage 1: premultiply product, unpremultiply numerator and overflow test
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      p1_pm[ch]  <= color_in[ch] * alpha_in + 32'd32767;
      p1_num[ch] <= {color_in[ch], 16'd0} - {16'd0, color_in[ch]} + {17'd0, alpha_in[15:1]};
      p1_sat[ch] <= ({color_in[ch], 16'd0} - {16'd0, color_in[ch]} +
                     {17'd0, alpha_in[15:1]}) >= {alpha_in, 16'd0};
    end
    p1_c <= color_in;
    p1_a <= alpha_in;
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    ytr_udiv u_div (
      .clk (clk),
      .num (p1_num[ch]),
      .den (p1_a),
      .quo (quo[ch])
    );
  end

  // Hold the other paths alongside the dividers
  always_ff @(posedge clk) begin
    pm_d[0]  <= p1_pm;
    sat_d[0] <= p1_sat;
    c_d[0]   <= p1_c;
    a_d[0]   <= p1_a;
    for (int k = 1; k < N; k++) begin
      pm_d[k]  <= pm_d[k-1];
      sat_d[k] <= sat_d[k-1];
      c_d[k]   <= c_d[k-1];
      a_d[k]   <= a_d[k-1];
    end
  end

  // Final stage: pick the action
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      priority if (alpha_plane && action == ytr_pkg::ACT_PREMUL) begin
        color_out[ch] <= ytr_pkg::div65535(pm_d[N-1][ch]);
      end else if (alpha_plane && action == ytr_pkg::ACT_UNPREMUL) begin
        priority if (a_d[N-1] == 16'd0) begin
          color_out[ch] <= 16'd0;
        end else if (sat_d[N-1][ch]) begin
          color_out[ch] <= 16'hFFFF;
        end else begin
          color_out[ch] <= quo[ch];
        end
      end else begin
        color_out[ch] <= c_d[N-1][ch];
      end
    end
    alpha_out <= a_d[N-1];
  end

endmodule

FILE: rtl/core/ytr_checker.sv
// ----------------------------------------------------------------------------
// ytr_checker: port-level checks for the pixel converter
// Watches the top level's ports for latency and error-result rules.
// ----------------------------------------------------------------------------
module ytr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ytr_pkg::res_t result
);

  localparam int LAT = ytr_pkg::LAT_TOTAL;

  // The converter never holds off a transfer
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // A result appears only a fixed latency after a transfer in
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transfer");

  // A range error zeroes every color and alpha field
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.data_error) |->
      (result.red == 16'd0 && result.green == 16'd0 &&
       result.blue == 16'd0 && result.alpha_out == 16'd0))
    else $error("error result carries data");

  // A transfer in always yields a result after the fixed latency
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transfer in without result");

endmodule

bind yuv_to_rgb_pixel_converter_top ytr_checker u_ytr_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: pixel converter testbench
// Drives pixels through the command port under several register settings,
// predicts each converted pixel and checks every result strobe in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register image kept by the testbench
  typedef struct {
    logic [1:0] depth;
    logic       full;
    logic [1:0] mode;
    logic       mono;
    logic [1:0] adepth;
    logic       afull;
    logic [1:0] act;
    logic       out8;
  } regs_t;

  // Signed division, rounding half away from zero
  function automatic longint div_round(longint num, longint den);
    if (num < 0) return -((-num + den / 2) / den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint sat16(longint v);
    if (v <= 0) return 0;
    if (v >= 65535) return 65535;
    return v;
  endfunction

  function automatic longint luma16(longint s, int bits, bit full);
    if (full) return sat16(div_round(s * 65535, (64'd1 << bits) - 1));
    return sat16(div_round((s - (16 << (bits - 8))) * 65535, 219 << (bits - 8)));
  endfunction

  function automatic longint chroma16(longint s, int bits, bit full);
    longint den;
    den = full ? ((64'd1 << bits) - 1) : (224 << (bits - 8));
    return div_round((s - (1 << (bits - 1))) * 65535, den);
  endfunction

  function automatic ytr_pkg::res_t convert_pixel(ytr_pkg::pix_t p, regs_t c);
    ytr_pkg::res_t o;
    int bits, abits;
    longint maxv, r, g, b, a, yf, cb, cr, kr, kgb, kgr, kb;
    bit err, has_a;
    longint ch[3];
    bits = c.depth == ytr_pkg::DEPTH_8 ? 8 : (c.depth == ytr_pkg::DEPTH_10 ? 10 : 12);
    maxv = (1 << bits) - 1;
    has_a = c.adepth != ytr_pkg::ADEPTH_NONE;
    abits = 6 + 2 * c.adepth;
    a = 65535;
    err = p.luma_sample > maxv;
    if (!c.mono && (p.cb_sample > maxv || p.cr_sample > maxv)) err = 1;
    if (has_a && p.alpha_level > ((1 << abits) - 1)) err = 1;
    o = '0;
    if (err) begin
      o.data_error = 1'b1;
      return o;
    end
    if (c.mono) begin
      r = luma16(p.luma_sample, bits, c.full);
      g = r;
      b = r;
    end else if (c.mode == ytr_pkg::MODE_IDENTITY) begin
      r = luma16(p.cr_sample, bits, c.full);
      g = luma16(p.luma_sample, bits, c.full);
      b = luma16(p.cb_sample, bits, c.full);
    end else begin
      case (c.mode)
        ytr_pkg::MODE_BT709: begin kr = 103206; kgb = 12276; kgr = 30679; kb = 121609; end
        ytr_pkg::MODE_BT601: begin kr = 91881; kgb = 22553; kgr = 46802; kb = 116130; end
        default:             begin kr = 96639; kgb = 10784; kgr = 37444; kb = 123299; end
      endcase
      yf = luma16(p.luma_sample, bits, c.full) * 65536;
      cb = chroma16(p.cb_sample, bits, c.full);
      cr = chroma16(p.cr_sample, bits, c.full);
      r = sat16(div_round(yf + kr * cr, 65536));
      g = sat16(div_round(yf - kgb * cb - kgr * cr, 65536));
      b = sat16(div_round(yf + kb * cb, 65536));
    end
    ch[0] = r; ch[1] = g; ch[2] = b;
    if (has_a) begin
      a = luma16(p.alpha_level, abits, c.afull);
      for (int i = 0; i < 3; i++) begin
        if (c.act == ytr_pkg::ACT_PREMUL) ch[i] = (ch[i] * a + 32767) / 65535;
        else if (c.act == ytr_pkg::ACT_UNPREMUL)
          ch[i] = (a == 0) ? 0 : sat16((ch[i] * 65535 + a / 2) / a);
      end
    end
    if (c.out8) begin
      for (int i = 0; i < 3; i++) ch[i] = (ch[i] * 255 + 32767) / 65535;
      a = (a * 255 + 32767) / 65535;
    end
    o.red = ch[0][15:0];
    o.green = ch[1][15:0];
    o.blue = ch[2][15:0];
    o.alpha_out = a[15:0];
    return o;
  endfunction

  // In-order store of predicted pixels and the mismatch count
  class pixel_scoreboard;
    ytr_pkg::res_t pending[$];
    int errors;
    function void note_pixel(ytr_pkg::pix_t p, regs_t c);
      pending.push_back(convert_pixel(p, c));
    endfunction
    function void check_result(ytr_pkg::res_t got);
      ytr_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp r=%0d g=%0d b=%0d a=%0d e=%0d",
                    "  got r=%0d g=%0d b=%0d a=%0d e=%0d"},
                   want.red, want.green, want.blue, want.alpha_out, want.data_error,
                   got.red, got.green, got.blue, got.alpha_out, got.data_error);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  ytr_pkg::pix_t pixel = '0;
  logic          done;
  ytr_pkg::res_t result;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [1:0]    cfg_wdata = '0;

  pixel_scoreboard sb = new();
  regs_t cfg;
  int idle_pct;
  int stall_cycles;

  yuv_to_rgb_pixel_converter_top dut (.*);

  always #5 clk = ~clk;

  // Check every result strobe; it is accepted at the edge ending its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 2000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write one register while the pipeline is empty; the caller drops cfg_we
  task automatic write_reg(logic [2:0] idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      ytr_pkg::REG_DEPTH:       cfg.depth = val;
      ytr_pkg::REG_FULL_RANGE:  cfg.full = val[0];
      ytr_pkg::REG_MATRIX:      cfg.mode = val;
      ytr_pkg::REG_MONO:        cfg.mono = val[0];
      ytr_pkg::REG_ALPHA_DEPTH: cfg.adepth = val;
      ytr_pkg::REG_ALPHA_FULL:  cfg.afull = val[0];
      ytr_pkg::REG_ALPHA_ACT:   cfg.act = val;
      default:                  cfg.out8 = val[0];
    endcase
  endtask

  task automatic set_all(logic [1:0] d, logic f, logic [1:0] m, logic mo,
                         logic [1:0] ad, logic af, logic [1:0] ac, logic o8);
    write_reg(ytr_pkg::REG_DEPTH, d);
    write_reg(ytr_pkg::REG_FULL_RANGE, {1'b0, f});
    write_reg(ytr_pkg::REG_MATRIX, m);
    write_reg(ytr_pkg::REG_MONO, {1'b0, mo});
    write_reg(ytr_pkg::REG_ALPHA_DEPTH, ad);
    write_reg(ytr_pkg::REG_ALPHA_FULL, {1'b0, af});
    write_reg(ytr_pkg::REG_ALPHA_ACT, ac);
    write_reg(ytr_pkg::REG_OUT8, {1'b0, o8});
    cfg_we <= 1'b0;
  endtask

  // Hold start high until the transfer, inserting random idle cycles first
  task automatic send_pixel(ytr_pkg::pix_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    sb.note_pixel(p, cfg);
  endtask

  // Drop start, wait for every predicted pixel, then let the pipe drain
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (ytr_pkg::LAT_TOTAL + 4) @(posedge clk);
  endtask

  // Draw a sample, mostly within the color or alpha depth, sometimes anywhere
  function automatic logic [11:0] rand_sample(int bits);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 12'($urandom);
    if (r < 16) return (r < 12) ? 12'd0 : 12'((1 << bits) - 1);
    return 12'($urandom_range((1 << bits) - 1));
  endfunction

  function automatic ytr_pkg::pix_t rand_pixel();
    ytr_pkg::pix_t p;
    int bits, abits;
    bits = cfg.depth == ytr_pkg::DEPTH_8 ? 8 : (cfg.depth == ytr_pkg::DEPTH_10 ? 10 : 12);
    abits = cfg.adepth == ytr_pkg::ADEPTH_NONE ? 12 : 6 + 2 * cfg.adepth;
    p.luma_sample = rand_sample(bits);
    p.cb_sample = rand_sample(bits);
    p.cr_sample = rand_sample(bits);
    p.alpha_level = rand_sample(abits);
    return p;
  endfunction

  initial begin
    ytr_pkg::pix_t p;
    cfg = '{ytr_pkg::DEPTH_8, 1'b1, ytr_pkg::MODE_BT709, 1'b0, ytr_pkg::ADEPTH_NONE,
            1'b1, ytr_pkg::ACT_LEAVE, 1'b0};
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes under reset defaults, then special cases
    send_pixel('{12'd0, 12'd0, 12'd0, 12'd0});
    send_pixel('{12'd255, 12'd255, 12'd255, 12'hFFF});
    send_pixel('{12'd256, 12'd128, 12'd128, 12'd0});
    send_pixel('{12'd128, 12'hFFF, 12'd0, 12'd0});
    drain();
    // limited range 12-bit, identity: below floor and above ceiling
    set_all(ytr_pkg::DEPTH_12, 1'b0, ytr_pkg::MODE_IDENTITY, 1'b0, ytr_pkg::ADEPTH_12,
            1'b0, ytr_pkg::ACT_UNPREMUL, 1'b0);
    send_pixel('{12'd0, 12'd4095, 12'd100, 12'd0});
    send_pixel('{12'd4095, 12'd0, 12'd4095, 12'd4095});
    send_pixel('{12'd2048, 12'd2048, 12'd2048, 12'd300});
    drain();
    // spare depth code and spare alpha action
    set_all(ytr_pkg::DEPTH_RSVD, 1'b1, ytr_pkg::MODE_BT2020, 1'b0, ytr_pkg::ADEPTH_8,
            1'b1, ytr_pkg::ACT_RSVD, 1'b1);
    send_pixel('{12'd4095, 12'd0, 12'd4095, 12'd255});
    send_pixel('{12'd0, 12'd0, 12'd0, 12'd256});
    drain();
    // monochrome ignores out-of-range chroma; premultiply by zero alpha
    set_all(ytr_pkg::DEPTH_10, 1'b0, ytr_pkg::MODE_BT601, 1'b1, ytr_pkg::ADEPTH_10,
            1'b1, ytr_pkg::ACT_PREMUL, 1'b0);
    send_pixel('{12'd1023, 12'hFFF, 12'hFFF, 12'd0});
    send_pixel('{12'd64, 12'd0, 12'd0, 12'd1023});
    send_pixel('{12'd1024, 12'd0, 12'd0, 12'd1023});
    send_pixel('{12'd500, 12'd0, 12'd0, 12'd1024});
    drain();

    // Random phases: three idling profiles, each over several settings
    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = (ph < 8) ? 19 : ((ph < 16) ? 68 : 0);
      if (ph % 8 == 0)
        set_all(ytr_pkg::DEPTH_8, 1'b1, ytr_pkg::MODE_IDENTITY, 1'b0, ytr_pkg::ADEPTH_NONE,
                1'b1, ytr_pkg::ACT_LEAVE, 1'b0);
      else if (ph % 8 == 1)
        set_all(ytr_pkg::DEPTH_12, 1'b0, ytr_pkg::MODE_BT2020, 1'b0, ytr_pkg::ADEPTH_12,
                1'b0, ytr_pkg::ACT_UNPREMUL, 1'b1);
      else
        set_all(2'($urandom), 1'($urandom), 2'($urandom), ($urandom_range(5) == 0),
                2'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
      for (int i = 0; i < 67; i++) begin
        p = rand_pixel();
        send_pixel(p);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/ytr_pkg.sv
rtl/core/ytr_norm.sv
rtl/core/ytr_matrix.sv
rtl/core/ytr_udiv.sv
rtl/core/ytr_alpha.sv
rtl/core/yuv_to_rgb_pixel_converter_top.sv
rtl/core/ytr_checker.sv
tb/tb.sv
